// ===== hdl/vn_pkg.sv =====
// Package: widths, pipeline depths and shared types for the vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;
  localparam int CompW  = 32;
  localparam int MagW   = 32;
  localparam int SumW   = 64;
  localparam int RootW  = 32;
  localparam int QW     = 31;
  localparam int FracB  = 30;
  localparam int SqrtSteps = 32;
  localparam int SqrtPerStage = 4;
  localparam int DivSteps = 31;
  localparam int DivPerStage = 4;
  localparam int DefaultSkid = 2;

  typedef logic signed [CompW-1:0] comp_t;

  // Side info carried with each word through the pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;
endpackage

// ===== hdl/vn_if.sv =====
// Interfaces for the input and result channels.
`timescale 1ns / 1ps
interface vn_in_if;
  import vn_pkg::*;
  logic  valid;
  logic  ready;
  comp_t x_in;
  comp_t y_in;
  comp_t z_in;
  modport source  (output valid, x_in, y_in, z_in, input ready);
  modport sink    (input valid, x_in, y_in, z_in, output ready);
  modport monitor (input valid, ready, x_in, y_in, z_in);
endinterface

interface vn_out_if;
  import vn_pkg::*;
  logic  valid;
  logic  ready;
  comp_t x_out;
  comp_t y_out;
  comp_t z_out;
  logic  zero_length;
  modport source  (output valid, x_out, y_out, z_out, zero_length, input ready);
  modport sink    (input valid, x_out, y_out, z_out, zero_length, output ready);
  modport monitor (input valid, ready, x_out, y_out, z_out, zero_length);
endinterface

// ===== hdl/vn_div.sv =====
// Pipelined restoring divider: q = floor((a*2^30 + r/2) / r), r >= a, r > 0.
`timescale 1ns / 1ps
module vn_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vn_pkg::MagW-1:0]   a,
  input  logic [vn_pkg::RootW-1:0]  r,
  output logic [vn_pkg::QW-1:0]     q
);
  import vn_pkg::*;
  localparam int NStg = (DivSteps + DivPerStage - 1) / DivPerStage;
  localparam int RemW = RootW + 1;

  // Numerator n = a*2^30 + r/2 is 63 bits; quotient is 31 bits. Remainder
  // is seeded with the top 32 bits of n, quotient bits come from the low 31.
  logic [62:0] num;
  assign num = {1'b0, a, {FracB{1'b0}}} + {32'd0, r[RootW-1:1]};

  logic [RemW-1:0]  rem_r [NStg];
  logic [QW-1:0]    qb_r  [NStg];
  logic [QW-1:0]    low_r [NStg];
  logic [RootW-1:0] d_r   [NStg];

  for (genvar g = 0; g < NStg; g++) begin : g_stg
    logic [RemW-1:0]  rem_in;
    logic [QW-1:0]    qb_in;
    logic [QW-1:0]    low_in;
    logic [RootW-1:0] d_in;
    logic [RemW-1:0]  rem_nxt;
    logic [QW-1:0]    qb_nxt;
    logic [QW-1:0]    low_nxt;
    if (g == 0) begin : g_src
      // First stage: n >> 31 is below r; leading quotient bit is zero.
      assign rem_in = {1'b0, num[62:QW]};
      assign qb_in  = '0;
      assign low_in = num[QW-1:0];
      assign d_in   = r;
    end else begin : g_src
      assign rem_in = rem_r[g-1];
      assign qb_in  = qb_r[g-1];
      assign low_in = low_r[g-1];
      assign d_in   = d_r[g-1];
    end
    always_comb begin
      logic [RemW:0] t;
      rem_nxt = rem_in;
      qb_nxt  = qb_in;
      low_nxt = low_in;
      for (int k = 0; k < DivPerStage; k++) begin
        if (g * DivPerStage + k < DivSteps) begin
          t = {rem_nxt, low_nxt[QW-1]};
          low_nxt = {low_nxt[QW-2:0], 1'b0};
          if (t >= {2'b00, d_in}) begin
            t = t - {2'b00, d_in};
            qb_nxt = {qb_nxt[QW-2:0], 1'b1};
          end else begin
            qb_nxt = {qb_nxt[QW-2:0], 1'b0};
          end
          rem_nxt = t[RemW-1:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        qb_r[g]  <= qb_nxt;
        low_r[g] <= low_nxt;
        d_r[g]   <= d_in;
      end
    end
  end

  assign q = qb_r[NStg-1];
endmodule

// ===== hdl/vector3_normalize.sv =====
// Top level: pipelined 3D vector normalizer, Q16.16 in, Q2.30 out.
`timescale 1ns / 1ps
// vector3_normalize accepts one vector every cycle while its occupancy
// count admits input and returns one unit vector per input in order. An
// input word passes one register stage for magnitude and scaling, one
// for the three squares, one for the sum, eight for the square root
// (four root bits each), eight for the dividers (four quotient bits
// each, three in the last) and one for the output queue before its
// result can be taken. The pipe itself never stalls; the occupancy count
// admits input only while the output queue (a word per stage ahead of it
// plus SkidDepth) holds a slot for every word in flight, so with the
// consumer ready a new vector enters every cycle. A zero vector yields
// zero components with zero_length set.
module vector3_normalize #(
  parameter int SkidDepth = vn_pkg::DefaultSkid
) (
  input logic clk,
  input logic rst_n,
  vn_in_if.sink    in_ch,
  vn_out_if.source out_ch
);
  import vn_pkg::*;
  localparam int SqStg = SqrtSteps / SqrtPerStage;
  localparam int DvStg = (DivSteps + DivPerStage - 1) / DivPerStage;
  localparam int Lat   = 3 + SqStg + DvStg;
  localparam int QD    = Lat + SkidDepth;
  localparam int CntW  = $clog2(QD + 1);
  localparam int PtrW  = (QD > 1) ? $clog2(QD) : 1;

  // Admission: take input while the queue has a slot for every word in flight
  logic en;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [Lat-1:0]  v_r;
  logic out_fire, in_fire;
  assign en = 1'b1;
  assign in_ch.ready = (cnt_r < CntW'(QD)) || ((cnt_r == CntW'(QD)) && out_fire);
  assign in_fire = in_ch.valid && in_ch.ready;

  // Stage 1: magnitudes, signs, normalizing shift
  logic [MagW-1:0] m0, m1, m2, mx;
  logic [2:0] neg0;
  always_comb begin
    neg0 = {in_ch.z_in[CompW-1], in_ch.y_in[CompW-1], in_ch.x_in[CompW-1]};
    m0 = neg0[0] ? (~in_ch.x_in + 1'b1) : in_ch.x_in;
    m1 = neg0[1] ? (~in_ch.y_in + 1'b1) : in_ch.y_in;
    m2 = neg0[2] ? (~in_ch.z_in + 1'b1) : in_ch.z_in;
    mx = m0 | m1 | m2;
  end
  // highest set bit below bit 30 wins; none needed when bit 30 or 31 is set
  logic [4:0] sh;
  always_comb begin
    sh = '0;
    for (int k = 0; k < FracB; k++) if (mx[k]) sh = 5'(FracB - k);
    if (mx[MagW-1:FracB] != '0) sh = '0;
  end
  logic [MagW-1:0] a_r [3];
  side_t s1_r;
  always_ff @(posedge clk) begin
    a_r[0] <= m0 << sh;
    a_r[1] <= m1 << sh;
    a_r[2] <= m2 << sh;
    s1_r.neg <= neg0;
    s1_r.zero <= (mx == '0);
  end

  // Stage 2: squares; stage 3: sum
  logic [SumW-1:0] sq_r [3];
  logic [MagW-1:0] a2_r [3];
  side_t s2_r;
  logic [SumW-1:0] sum_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= SumW'(a_r[i]) * SumW'(a_r[i]);
      a2_r[i] <= a_r[i];
    end
    s2_r <= s1_r;
    sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end
  logic [MagW-1:0] a3_r [3];
  side_t s3_r;
  always_ff @(posedge clk) begin
    a3_r <= a2_r;
    s3_r <= s2_r;
  end

  // Square root: restoring digit recurrence, one root bit per step
  logic [SumW-1:0]  sv_r  [SqStg];
  logic [RootW-1:0] rt_r  [SqStg];
  logic [RootW+1:0] rm_r  [SqStg];
  logic [MagW-1:0]  sa_r  [SqStg][3];
  side_t            ss_r  [SqStg];
  for (genvar g = 0; g < SqStg; g++) begin : g_sq
    logic [SumW-1:0]  v_in;
    logic [RootW-1:0] rt_in;
    logic [RootW+1:0] rm_in;
    logic [MagW-1:0]  a_in [3];
    side_t            s_in;
    logic [SumW-1:0] v_nxt;
    logic [RootW-1:0] rt_nxt;
    logic [RootW+1:0] rm_nxt;
    if (g == 0) begin : g_src
      assign v_in  = sum_r;
      assign rt_in = '0;
      assign rm_in = '0;
      assign a_in  = a3_r;
      assign s_in  = s3_r;
    end else begin : g_src
      assign v_in  = sv_r[g-1];
      assign rt_in = rt_r[g-1];
      assign rm_in = rm_r[g-1];
      assign a_in  = sa_r[g-1];
      assign s_in  = ss_r[g-1];
    end
    always_comb begin
      logic [RootW+1:0] t, tr;
      v_nxt = v_in; rt_nxt = rt_in; rm_nxt = rm_in;
      for (int k = 0; k < SqrtPerStage; k++) begin
        t  = {rm_nxt[RootW-1:0], v_nxt[SumW-1:SumW-2]};
        tr = {rt_nxt, 2'b01};
        v_nxt = {v_nxt[SumW-3:0], 2'b00};
        if (t >= tr) begin
          rm_nxt = t - tr;
          rt_nxt = {rt_nxt[RootW-2:0], 1'b1};
        end else begin
          rm_nxt = t;
          rt_nxt = {rt_nxt[RootW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      sv_r[g] <= v_nxt; rt_r[g] <= rt_nxt; rm_r[g] <= rm_nxt;
      sa_r[g] <= a_in; ss_r[g] <= s_in;
    end
  end

  // Dividers, with side info delayed alongside
  logic [QW-1:0] q [3];
  logic [RootW-1:0] rdiv;
  assign rdiv = ss_r[SqStg-1].zero ? RootW'(1) : rt_r[SqStg-1];
  for (genvar i = 0; i < 3; i++) begin : g_div
    vn_div u_div (.clk(clk), .en(en), .a(sa_r[SqStg-1][i]), .r(rdiv), .q(q[i]));
  end
  side_t sd_r [DvStg];
  always_ff @(posedge clk) begin
    sd_r[0] <= ss_r[SqStg-1];
    for (int g = 1; g < DvStg; g++) sd_r[g] <= sd_r[g-1];
  end

  // Valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[Lat-2:0], in_fire};
  end

  // Result queue
  logic [3*CompW:0] qm [QD];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [3*CompW:0] wd;
  always_comb begin
    comp_t cx, cy, cz;
    cx = sd_r[DvStg-1].zero ? '0 : (sd_r[DvStg-1].neg[0] ? -comp_t'(q[0]) : comp_t'(q[0]));
    cy = sd_r[DvStg-1].zero ? '0 : (sd_r[DvStg-1].neg[1] ? -comp_t'(q[1]) : comp_t'(q[1]));
    cz = sd_r[DvStg-1].zero ? '0 : (sd_r[DvStg-1].neg[2] ? -comp_t'(q[2]) : comp_t'(q[2]));
    wd = {sd_r[DvStg-1].zero, cz, cy, cx};
  end
  assign out_fire = out_ch.valid && out_ch.ready;
  always_ff @(posedge clk) if (v_r[Lat-1]) qm[wp_r] <= wd;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (v_r[Lat-1]) wp_r <= (wp_r == PtrW'(QD-1)) ? '0 : wp_r + 1'b1;
      if (out_fire) rp_r <= (rp_r == PtrW'(QD-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end
  // cnt counts items in flight plus queued
  always_comb cnt_nxt = cnt_r + CntW'(in_fire) - CntW'(out_fire);
  logic [CntW-1:0] qcnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) qcnt_r <= '0;
    else qcnt_r <= qcnt_r + CntW'(v_r[Lat-1]) - CntW'(out_fire);
  end
  assign out_ch.valid = (qcnt_r != '0);
  assign {out_ch.zero_length, out_ch.z_out, out_ch.y_out, out_ch.x_out} = qm[rp_r];

  // Checks
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(QD))
    else $error("occupancy overflow");
  a_q: assert property (@(posedge clk) disable iff (!rst_n) qcnt_r <= cnt_r)
    else $error("queue count exceeds total");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (v_r == '0)) else $error("valid without count");
endmodule

// ===== tb/vn_checker.sv =====
// Checker: watches both channels, predicts unit vectors and compares results.
`timescale 1ns / 1ps
module vn_checker (
  input  logic clk,
  input  logic rst_n,
  vn_in_if.monitor  in_mon,
  vn_out_if.monitor out_mon,
  output int       fail_count,
  output int       pending,
  output int       results_seen,
  output int       zero_seen
);
  import vn_pkg::*;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  zero;
  } unit_vec_t;

  unit_vec_t unit_q[$];

  // Truncating integer square root, bit pair at a time
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Expected unit vector for one input vector
  function automatic unit_vec_t normalize(input comp_t x, input comp_t y, input comp_t z);
    logic [63:0] mag [3];
    logic        neg [3];
    logic [31:0] raw [3];
    logic [63:0] peak, sum, root, q;
    comp_t       res [3];
    unit_vec_t   r;
    raw[0] = x; raw[1] = y; raw[2] = z;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = raw[i][31];
      mag[i] = neg[i] ? (64'h1_0000_0000 - {32'd0, raw[i]}) : {32'd0, raw[i]};
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.zero = 1'b1;
      return r;
    end
    while (peak < (64'd1 << FracB)) begin
      peak = peak << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    root = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FracB) + (root >> 1)) / root;
      if (q > (64'd1 << FracB)) q = 64'd1 << FracB;
      res[i] = neg[i] ? comp_t'(-q[31:0]) : comp_t'(q[31:0]);
    end
    r.x = res[0]; r.y = res[1]; r.z = res[2]; r.zero = 1'b0;
    return r;
  endfunction

  assign pending = unit_q.size();

  always @(posedge clk) begin
    unit_vec_t exp_v;
    if (!rst_n) begin
      fail_count   <= 0;
      results_seen <= 0;
      zero_seen    <= 0;
      unit_q.delete();
    end else begin
      // predict on each accepted input word
      if (in_mon.valid && in_mon.ready)
        unit_q.push_back(normalize(in_mon.x_in, in_mon.y_in, in_mon.z_in));
      // compare each accepted result word
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (out_mon.zero_length) zero_seen <= zero_seen + 1;
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h zero=%b", $time,
                   out_mon.x_out, out_mon.y_out, out_mon.z_out, out_mon.zero_length);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = unit_q.pop_front();
          if (out_mon.x_out !== exp_v.x || out_mon.y_out !== exp_v.y ||
              out_mon.z_out !== exp_v.z || out_mon.zero_length !== exp_v.zero) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h zero=%b", $time,
                     exp_v.x, exp_v.y, exp_v.z, exp_v.zero);
            $display("%0t:          actual   x=%h y=%h z=%h zero=%b", $time,
                     out_mon.x_out, out_mon.y_out, out_mon.z_out, out_mon.zero_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_vector3_normalize.sv =====
// Testbench top: drives vectors into the normalizer and reports the verdict.
`timescale 1ns / 1ps
module tb_vector3_normalize;
  import vn_pkg::*;

  localparam int RandItems = 1030;
  localparam int DrainCycles = 40;

  logic clk;
  logic rst_n;
  int   fail_count, pending, results_seen, zero_seen;
  int   send_idle_pct, recv_idle_pct;

  vn_in_if  in_ch ();
  vn_out_if out_ch ();

  vector3_normalize uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  vn_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.monitor), .out_mon(out_ch.monitor),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .zero_seen(zero_seen)
  );

  // 20 ns clock
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one word; hold it until accepted
  task automatic send_vec(input comp_t x, input comp_t y, input comp_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_in  <= x;
    in_ch.y_in  <= y;
    in_ch.z_in  <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random component: full range, small and mid-size values, zero, or extremes
  function automatic comp_t rand_comp();
    case ($urandom_range(7))
      0:       return comp_t'($urandom_range(15)) - 8;
      1:       return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      2:       return comp_t'($urandom_range(65535)) - 32768;
      3:       return 0;
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    comp_t a, b, c;
    in_ch.valid <= 1'b0;
    in_ch.x_in  <= '0;
    in_ch.y_in  <= '0;
    in_ch.z_in  <= '0;
    send_idle_pct = 31;
    recv_idle_pct = 55;
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: zero, single axes, extremes, tiny, mixed signs
    send_vec(0, 0, 0);
    send_vec(32'sh0001_0000, 0, 0);
    send_vec(0, -32'sh0001_0000, 0);
    send_vec(0, 0, 32'sh8000_0000);
    send_vec(32'sh7fff_ffff, 0, 0);
    send_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_vec(32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_vec(1, 0, 0);
    send_vec(0, 0, -1);
    send_vec(1, 1, 1);
    send_vec(-1, 1, -1);
    send_vec(3, 4, 0);
    send_vec(-3, 0, 4);
    send_vec(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f);
    send_vec(32'sh7fff_ffff, 1, -1);
    send_vec(0, 0, 0);
    send_vec(32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff);

    // hold off until the pipe is empty
    wait_drained();

    for (int i = 0; i < RandItems; i++) begin
      if (i == RandItems / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 31;
      end else if (i == 2 * RandItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      a = rand_comp();
      b = rand_comp();
      c = rand_comp();
      send_vec(a, b, c);
    end
    wait_drained();
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d vectors (%0d random) over three stall mixes; %0d results, %0d zero.",
             RandItems + 18, RandItems, results_seen, zero_seen);
    if (fail_count == 0) begin
      $display("[vector3_normalize] OK");
    end else begin
      $display("[vector3_normalize] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("[vector3_normalize] ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/vn_pkg.sv
hdl/vn_if.sv
hdl/vn_div.sv
hdl/vector3_normalize.sv
tb/vn_checker.sv
tb/tb_vector3_normalize.sv
